// ----- design/kdr_pkg.sv -----
// Shared types, codes and constants of the k-d tree radius search core.
`timescale 1ns / 1ps
package kdr_pkg;

   localparam int CAPACITY_DEF   = 64;
   localparam int COORD_BITS_DEF = 20;
   localparam int ID_W           = 16;
   localparam int MAX_RESULTS    = 64;
   localparam int HIT_W          = $clog2(MAX_RESULTS + 1);

   typedef enum logic [2:0] {
      FUNC_CLEAR  = 3'd0,
      FUNC_ADD    = 3'd1,
      FUNC_DELETE = 3'd2,
      FUNC_MEMBER = 3'd3,
      FUNC_QUERY  = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_NOTFOUND = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef enum logic [4:0] {
      OP_NOP, OP_CAPTURE, OP_CLEAR, OP_ADD, OP_SCAN_INIT, OP_SCAN_RD, OP_SCAN_NEXT,
      OP_FOUND, OP_DEL_RDLAST, OP_DEL_MOVE, OP_EMIT_ONE, OP_I_CLR, OP_INIT_WR,
      OP_ROOT, OP_SRT_START, OP_SRT_RDKEY, OP_SRT_KEY, OP_SRT_KV, OP_SRT_PLACE,
      OP_SRT_RDPREV, OP_SRT_PREV, OP_SRT_SHIFT, OP_SPLIT, OP_POP, OP_WK_START,
      OP_WK_RDORD, OP_WK_RDSLOT, OP_WK_DIFF, OP_WK_SQ, OP_WK_SUM, OP_WK_TAKE,
      OP_EMIT_LAST
   } dp_op_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DISPATCH, ST_SCAN_RD, ST_SCAN_CHK, ST_DEL_MOVE, ST_EMIT_ONE,
      ST_RB_INIT, ST_RB_NODE, ST_SRT_I, ST_SRT_KEY, ST_SRT_KV, ST_SRT_J,
      ST_SRT_PREV, ST_SRT_CMP, ST_RB_SPLIT, ST_RB_POP, ST_WK_NODE, ST_WK_SLOT,
      ST_WK_DIFF, ST_WK_SQ, ST_WK_SUM, ST_WK_TAKE, ST_WK_SPLIT, ST_WK_POP,
      ST_WK_FLUSH
   } ctrl_state_type;

   typedef struct packed {
      dp_op_type op;
      logic      bounds;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] func;
      logic       full;
      logic       scan_end;
      logic       id_eq;
      logic       tree_valid;
      logic       srt_end;
      logic       j_zero;
      logic       prev_gt;
      logic       cnt_zero;
      logic       left_go;
      logic       stack_empty;
      logic       hit;
      logic       pend_valid;
      logic       hits_full;
      logic       out_free;
   } dp_stat_type;

endpackage

// ----- design/kdr_ctrl.sv -----
// Controller state machine: sequences datapath operations for each item.
`timescale 1ns / 1ps
module kdr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  kdr_pkg::dp_stat_type stat,
   output kdr_pkg::dp_cmd_type  cmd
);

   kdr_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kdr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.op     = kdr_pkg::OP_NOP;
      cmd.bounds = 1'b0;
      req_ready  = 1'b0;
      case (state_ff)
         kdr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = kdr_pkg::OP_CAPTURE;
               state_in = kdr_pkg::ST_DISPATCH;
            end
         end
         kdr_pkg::ST_DISPATCH: begin
            case (stat.func)
               kdr_pkg::FUNC_CLEAR: begin
                  cmd.op   = kdr_pkg::OP_CLEAR;
                  state_in = kdr_pkg::ST_EMIT_ONE;
               end
               kdr_pkg::FUNC_ADD: begin
                  cmd.op   = kdr_pkg::OP_ADD;
                  state_in = kdr_pkg::ST_EMIT_ONE;
               end
               kdr_pkg::FUNC_DELETE, kdr_pkg::FUNC_MEMBER: begin
                  cmd.op   = kdr_pkg::OP_SCAN_INIT;
                  state_in = kdr_pkg::ST_SCAN_RD;
               end
               kdr_pkg::FUNC_QUERY: begin
                  if (stat.tree_valid) begin
                     cmd.op   = kdr_pkg::OP_WK_START;
                     state_in = kdr_pkg::ST_WK_NODE;
                  end else begin
                     cmd.op   = kdr_pkg::OP_I_CLR;
                     state_in = kdr_pkg::ST_RB_INIT;
                  end
               end
               default: state_in = kdr_pkg::ST_EMIT_ONE;
            endcase
         end
         kdr_pkg::ST_SCAN_RD: begin
            if (stat.scan_end) begin
               state_in = kdr_pkg::ST_EMIT_ONE;
            end else begin
               cmd.op   = kdr_pkg::OP_SCAN_RD;
               state_in = kdr_pkg::ST_SCAN_CHK;
            end
         end
         kdr_pkg::ST_SCAN_CHK: begin
            if (!stat.id_eq) begin
               cmd.op   = kdr_pkg::OP_SCAN_NEXT;
               state_in = kdr_pkg::ST_SCAN_RD;
            end else if (stat.func == kdr_pkg::FUNC_DELETE) begin
               cmd.op   = kdr_pkg::OP_DEL_RDLAST;
               state_in = kdr_pkg::ST_DEL_MOVE;
            end else begin
               cmd.op   = kdr_pkg::OP_FOUND;
               state_in = kdr_pkg::ST_EMIT_ONE;
            end
         end
         kdr_pkg::ST_DEL_MOVE: begin
            cmd.op   = kdr_pkg::OP_DEL_MOVE;
            state_in = kdr_pkg::ST_EMIT_ONE;
         end
         kdr_pkg::ST_EMIT_ONE: begin
            if (stat.out_free) begin
               cmd.op   = kdr_pkg::OP_EMIT_ONE;
               state_in = kdr_pkg::ST_IDLE;
            end
         end
         kdr_pkg::ST_RB_INIT: begin
            if (stat.scan_end) begin
               cmd.op   = kdr_pkg::OP_ROOT;
               state_in = kdr_pkg::ST_RB_NODE;
            end else begin
               cmd.op = kdr_pkg::OP_INIT_WR;
            end
         end
         kdr_pkg::ST_RB_NODE: begin
            if (stat.cnt_zero) begin
               state_in = kdr_pkg::ST_RB_POP;
            end else begin
               cmd.op   = kdr_pkg::OP_SRT_START;
               state_in = kdr_pkg::ST_SRT_I;
            end
         end
         kdr_pkg::ST_SRT_I: begin
            if (stat.srt_end) begin
               state_in = kdr_pkg::ST_RB_SPLIT;
            end else begin
               cmd.op   = kdr_pkg::OP_SRT_RDKEY;
               state_in = kdr_pkg::ST_SRT_KEY;
            end
         end
         kdr_pkg::ST_SRT_KEY: begin
            cmd.op   = kdr_pkg::OP_SRT_KEY;
            state_in = kdr_pkg::ST_SRT_KV;
         end
         kdr_pkg::ST_SRT_KV: begin
            cmd.op   = kdr_pkg::OP_SRT_KV;
            state_in = kdr_pkg::ST_SRT_J;
         end
         kdr_pkg::ST_SRT_J: begin
            if (stat.j_zero) begin
               cmd.op   = kdr_pkg::OP_SRT_PLACE;
               state_in = kdr_pkg::ST_SRT_I;
            end else begin
               cmd.op   = kdr_pkg::OP_SRT_RDPREV;
               state_in = kdr_pkg::ST_SRT_PREV;
            end
         end
         kdr_pkg::ST_SRT_PREV: begin
            cmd.op   = kdr_pkg::OP_SRT_PREV;
            state_in = kdr_pkg::ST_SRT_CMP;
         end
         kdr_pkg::ST_SRT_CMP: begin
            if (stat.prev_gt) begin
               cmd.op   = kdr_pkg::OP_SRT_SHIFT;
               state_in = kdr_pkg::ST_SRT_J;
            end else begin
               cmd.op   = kdr_pkg::OP_SRT_PLACE;
               state_in = kdr_pkg::ST_SRT_I;
            end
         end
         kdr_pkg::ST_RB_SPLIT: begin
            cmd.op   = kdr_pkg::OP_SPLIT;
            state_in = stat.left_go ? kdr_pkg::ST_RB_NODE : kdr_pkg::ST_RB_POP;
         end
         kdr_pkg::ST_RB_POP: begin
            if (stat.stack_empty) begin
               cmd.op   = kdr_pkg::OP_WK_START;
               state_in = kdr_pkg::ST_WK_NODE;
            end else begin
               cmd.op   = kdr_pkg::OP_POP;
               state_in = kdr_pkg::ST_RB_NODE;
            end
         end
         kdr_pkg::ST_WK_NODE: begin
            if (stat.cnt_zero) begin
               state_in = kdr_pkg::ST_WK_FLUSH;
            end else begin
               cmd.op   = kdr_pkg::OP_WK_RDORD;
               state_in = kdr_pkg::ST_WK_SLOT;
            end
         end
         kdr_pkg::ST_WK_SLOT: begin
            cmd.op   = kdr_pkg::OP_WK_RDSLOT;
            state_in = kdr_pkg::ST_WK_DIFF;
         end
         kdr_pkg::ST_WK_DIFF: begin
            cmd.op   = kdr_pkg::OP_WK_DIFF;
            state_in = kdr_pkg::ST_WK_SQ;
         end
         kdr_pkg::ST_WK_SQ: begin
            cmd.op   = kdr_pkg::OP_WK_SQ;
            state_in = kdr_pkg::ST_WK_SUM;
         end
         kdr_pkg::ST_WK_SUM: begin
            cmd.op   = kdr_pkg::OP_WK_SUM;
            state_in = kdr_pkg::ST_WK_TAKE;
         end
         kdr_pkg::ST_WK_TAKE: begin
            if (!stat.hit) begin
               state_in = kdr_pkg::ST_WK_SPLIT;
            end else if (!stat.pend_valid || stat.out_free) begin
               cmd.op   = kdr_pkg::OP_WK_TAKE;
               state_in = stat.hits_full ? kdr_pkg::ST_WK_FLUSH : kdr_pkg::ST_WK_SPLIT;
            end
         end
         kdr_pkg::ST_WK_SPLIT: begin
            cmd.op     = kdr_pkg::OP_SPLIT;
            cmd.bounds = 1'b1;
            state_in   = stat.left_go ? kdr_pkg::ST_WK_NODE : kdr_pkg::ST_WK_POP;
         end
         kdr_pkg::ST_WK_POP: begin
            if (stat.stack_empty) begin
               state_in = kdr_pkg::ST_WK_FLUSH;
            end else begin
               cmd.op   = kdr_pkg::OP_POP;
               state_in = kdr_pkg::ST_WK_NODE;
            end
         end
         kdr_pkg::ST_WK_FLUSH: begin
            if (stat.out_free) begin
               cmd.op   = kdr_pkg::OP_EMIT_LAST;
               state_in = kdr_pkg::ST_IDLE;
            end
         end
         default: state_in = kdr_pkg::ST_IDLE;
      endcase
   end

endmodule

// ----- design/kdr_datapath.sv -----
// Datapath: entry table, tree order memory, node stack, distance unit, result register.
`timescale 1ns / 1ps
module kdr_datapath #(
   parameter int CAPACITY   = kdr_pkg::CAPACITY_DEF,
   parameter int COORD_BITS = kdr_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  kdr_pkg::dp_cmd_type           cmd,
   output kdr_pkg::dp_stat_type          stat,
   input  logic [2:0]                    req_func,
   input  logic [kdr_pkg::ID_W-1:0]      req_entry_id,
   input  logic signed [COORD_BITS-1:0]  req_pos_x,
   input  logic signed [COORD_BITS-1:0]  req_pos_y,
   input  logic signed [COORD_BITS-1:0]  req_pos_z,
   input  logic [COORD_BITS-2:0]         req_radius,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [kdr_pkg::ID_W-1:0]      rsp_match_id,
   output logic                          rsp_match_valid,
   output logic                          rsp_present,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_last
);

   localparam int C       = COORD_BITS;
   localparam int IW      = kdr_pkg::ID_W;
   localparam int IDX_W   = $clog2(CAPACITY);
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int SLOT_W  = 3 * C + IW;
   localparam int STACK_D = $clog2(CAPACITY + 1) + 1;
   localparam int SP_W    = $clog2(STACK_D + 1);
   localparam int SPI_W   = $clog2(STACK_D);
   localparam int DIFF_W  = C + 1;
   localparam int SQ_W    = 2 * DIFF_W;
   localparam int SUM_W   = SQ_W + 2;
   localparam int R2_W    = 2 * (C - 1);
   localparam int BND_W   = C + 2;
   localparam int HIT_W   = kdr_pkg::HIT_W;

   function automatic logic signed [C-1:0] coord_of(input logic [SLOT_W-1:0] e,
                                                     input kdr_pkg::axis_type a);
      case (a)
         kdr_pkg::AXIS_X: coord_of = e[C-1:0];
         kdr_pkg::AXIS_Y: coord_of = e[2*C-1:C];
         default:         coord_of = e[3*C-1:2*C];
      endcase
   endfunction

   function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [C-1:0] a,
                                                   input logic signed [C-1:0] b);
      logic signed [DIFF_W-1:0] d;
      d = $signed({a[C-1], a}) - $signed({b[C-1], b});
      abs_diff = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
   endfunction

   // memories
   logic [SLOT_W-1:0] slot_mem [CAPACITY];
   logic [IDX_W-1:0]  order_mem [CAPACITY];
   logic [SLOT_W-1:0] slot_rd_ff;
   logic [IDX_W-1:0]  order_rd_ff;
   logic              slot_we, slot_re, order_we, order_re;
   logic [IDX_W-1:0]  slot_wa, slot_ra, order_wa, order_ra, order_wd;
   logic [SLOT_W-1:0] slot_wd;

   // node stack
   logic [CNT_W-1:0]  stk_lo [STACK_D];
   logic [CNT_W-1:0]  stk_cnt [STACK_D];
   kdr_pkg::axis_type stk_axis [STACK_D];
   logic              push;
   logic [SPI_W-1:0]  top_idx;

   // registers
   logic [2:0]          func_ff, func_in;
   logic [IW-1:0]       id_ff, id_in;
   logic signed [C-1:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic [C-2:0]        r_ff, r_in;
   logic [R2_W-1:0]     r2_ff, r2_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                tv_ff, tv_in;
   kdr_pkg::status_type st_ff, st_in;
   logic                pr_ff, pr_in;
   logic [CNT_W-1:0]    i_ff, i_in, j_ff, j_in;
   logic [IDX_W-1:0]    key_ff, key_in, tmp_ff, tmp_in;
   logic signed [C-1:0] kv_ff, kv_in;
   logic [CNT_W-1:0]    lo_ff, lo_in, cnt_ff, cnt_in;
   kdr_pkg::axis_type   axis_ff, axis_in;
   logic [SP_W-1:0]     sp_ff, sp_in;
   logic [DIFF_W-1:0]   dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic [SQ_W-1:0]     sqx_ff, sqx_in, sqy_ff, sqy_in, sqz_ff, sqz_in;
   logic                lok_ff, lok_in, rok_ff, rok_in, hit_ff, hit_in;
   logic [IW-1:0]       nid_ff, nid_in, pend_ff, pend_in;
   logic                pend_v_ff, pend_v_in;
   logic [HIT_W-1:0]    hits_ff, hits_in;
   logic                ov_ff, ov_in;
   logic [IW-1:0]       oid_ff, oid_in;
   logic                omv_ff, omv_in, opr_ff, opr_in, olast_ff, olast_in;
   logic [1:0]          ost_ff, ost_in;

   // derived values
   logic [CNT_W-1:0]    mid, r_lo, r_cnt;
   kdr_pkg::axis_type   nxt_axis;
   logic                out_free, push_ok;
   logic signed [C-1:0] p_val, c_val;
   logic signed [BND_W-1:0] c_ext, p_ext, r_ext;
   logic [SUM_W-1:0]    sq_sum;

   assign mid      = cnt_ff >> 1;
   assign r_lo     = lo_ff + mid + CNT_W'(1);
   assign r_cnt    = cnt_ff - mid - CNT_W'(1);
   assign out_free = !ov_ff || rsp_ready;
   assign push_ok  = ((mid + CNT_W'(1)) < cnt_ff) && (!cmd.bounds || rok_ff);
   assign top_idx  = SPI_W'(sp_ff - SP_W'(1));
   assign p_val    = coord_of(slot_rd_ff, axis_ff);
   assign c_val    = coord_of({{IW{1'b0}}, cz_ff, cy_ff, cx_ff}, axis_ff);
   assign c_ext    = BND_W'(c_val);
   assign p_ext    = BND_W'(p_val);
   assign r_ext    = $signed({3'b000, r_ff});
   assign sq_sum   = SUM_W'(sqx_ff) + SUM_W'(sqy_ff) + SUM_W'(sqz_ff);

   always_comb begin
      case (axis_ff)
         kdr_pkg::AXIS_X: nxt_axis = kdr_pkg::AXIS_Y;
         kdr_pkg::AXIS_Y: nxt_axis = kdr_pkg::AXIS_Z;
         default:         nxt_axis = kdr_pkg::AXIS_X;
      endcase
   end

   always_comb begin
      stat.func        = func_ff;
      stat.full        = (count_ff == CNT_W'(CAPACITY));
      stat.scan_end    = (i_ff >= count_ff);
      stat.id_eq       = (slot_rd_ff[SLOT_W-1 -: IW] == id_ff);
      stat.tree_valid  = tv_ff;
      stat.srt_end     = (i_ff >= cnt_ff);
      stat.j_zero      = (j_ff == '0);
      stat.prev_gt     = (p_val > kv_ff);
      stat.cnt_zero    = (cnt_ff == '0);
      stat.left_go     = (mid != '0) && (!cmd.bounds || lok_ff);
      stat.stack_empty = (sp_ff == '0);
      stat.hit         = hit_ff;
      stat.pend_valid  = pend_v_ff;
      stat.hits_full   = (hits_ff == HIT_W'(kdr_pkg::MAX_RESULTS - 1));
      stat.out_free    = out_free;
   end

   always_comb begin
      func_in = func_ff; id_in = id_ff; cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff;
      r_in = r_ff; r2_in = r2_ff; count_in = count_ff; tv_in = tv_ff;
      st_in = st_ff; pr_in = pr_ff; i_in = i_ff; j_in = j_ff;
      key_in = key_ff; tmp_in = tmp_ff; kv_in = kv_ff;
      lo_in = lo_ff; cnt_in = cnt_ff; axis_in = axis_ff; sp_in = sp_ff;
      dx_in = dx_ff; dy_in = dy_ff; dz_in = dz_ff;
      sqx_in = sqx_ff; sqy_in = sqy_ff; sqz_in = sqz_ff;
      lok_in = lok_ff; rok_in = rok_ff; hit_in = hit_ff; nid_in = nid_ff;
      pend_in = pend_ff; pend_v_in = pend_v_ff; hits_in = hits_ff;
      ov_in = ov_ff && !rsp_ready;
      oid_in = oid_ff; omv_in = omv_ff; opr_in = opr_ff; ost_in = ost_ff;
      olast_in = olast_ff;
      slot_we = 1'b0; slot_re = 1'b0; order_we = 1'b0; order_re = 1'b0;
      slot_wa = '0; slot_ra = '0; order_wa = '0; order_ra = '0; order_wd = '0;
      slot_wd = {id_ff, cz_ff, cy_ff, cx_ff};
      push = 1'b0;
      case (cmd.op)
         kdr_pkg::OP_CAPTURE: begin
            func_in = req_func; id_in = req_entry_id;
            cx_in = req_pos_x; cy_in = req_pos_y; cz_in = req_pos_z; r_in = req_radius;
            st_in = kdr_pkg::STATUS_OK; pr_in = 1'b0;
         end
         kdr_pkg::OP_CLEAR: begin
            count_in = '0; tv_in = 1'b0;
         end
         kdr_pkg::OP_ADD: begin
            if (count_ff == CNT_W'(CAPACITY)) begin
               st_in = kdr_pkg::STATUS_FULL;
            end else begin
               slot_we  = 1'b1;
               slot_wa  = count_ff[IDX_W-1:0];
               count_in = count_ff + CNT_W'(1);
               tv_in    = 1'b0;
            end
         end
         kdr_pkg::OP_SCAN_INIT: begin
            i_in  = '0;
            st_in = (func_ff == kdr_pkg::FUNC_DELETE) ? kdr_pkg::STATUS_NOTFOUND
                                                     : kdr_pkg::STATUS_OK;
         end
         kdr_pkg::OP_SCAN_RD: begin
            slot_re = 1'b1; slot_ra = i_ff[IDX_W-1:0];
         end
         kdr_pkg::OP_SCAN_NEXT: i_in = i_ff + CNT_W'(1);
         kdr_pkg::OP_FOUND:     pr_in = 1'b1;
         kdr_pkg::OP_DEL_RDLAST: begin
            slot_re = 1'b1; slot_ra = IDX_W'(count_ff - CNT_W'(1));
         end
         kdr_pkg::OP_DEL_MOVE: begin
            slot_we  = 1'b1; slot_wa = i_ff[IDX_W-1:0]; slot_wd = slot_rd_ff;
            count_in = count_ff - CNT_W'(1);
            tv_in    = 1'b0;
            st_in    = kdr_pkg::STATUS_OK;
         end
         kdr_pkg::OP_EMIT_ONE: begin
            ov_in = 1'b1; oid_in = '0; omv_in = 1'b0; opr_in = pr_ff;
            ost_in = st_ff; olast_in = 1'b1;
         end
         kdr_pkg::OP_I_CLR: i_in = '0;
         kdr_pkg::OP_INIT_WR: begin
            order_we = 1'b1; order_wa = i_ff[IDX_W-1:0]; order_wd = i_ff[IDX_W-1:0];
            i_in = i_ff + CNT_W'(1);
         end
         kdr_pkg::OP_ROOT: begin
            lo_in = '0; cnt_in = count_ff; axis_in = kdr_pkg::AXIS_X; sp_in = '0;
         end
         kdr_pkg::OP_SRT_START: i_in = CNT_W'(1);
         kdr_pkg::OP_SRT_RDKEY: begin
            order_re = 1'b1; order_ra = IDX_W'(lo_ff + i_ff);
         end
         kdr_pkg::OP_SRT_KEY: begin
            key_in = order_rd_ff; slot_re = 1'b1; slot_ra = order_rd_ff;
         end
         kdr_pkg::OP_SRT_KV: begin
            kv_in = p_val; j_in = i_ff;
         end
         kdr_pkg::OP_SRT_PLACE: begin
            order_we = 1'b1; order_wa = IDX_W'(lo_ff + j_ff); order_wd = key_ff;
            i_in = i_ff + CNT_W'(1);
         end
         kdr_pkg::OP_SRT_RDPREV: begin
            order_re = 1'b1; order_ra = IDX_W'(lo_ff + j_ff - CNT_W'(1));
         end
         kdr_pkg::OP_SRT_PREV: begin
            tmp_in = order_rd_ff; slot_re = 1'b1; slot_ra = order_rd_ff;
         end
         kdr_pkg::OP_SRT_SHIFT: begin
            order_we = 1'b1; order_wa = IDX_W'(lo_ff + j_ff); order_wd = tmp_ff;
            j_in = j_ff - CNT_W'(1);
         end
         kdr_pkg::OP_SPLIT: begin
            // right child waits on the stack, left child is taken next
            if (push_ok) begin
               push  = 1'b1;
               sp_in = sp_ff + SP_W'(1);
            end
            cnt_in  = mid;
            axis_in = nxt_axis;
         end
         kdr_pkg::OP_POP: begin
            lo_in = stk_lo[top_idx]; cnt_in = stk_cnt[top_idx];
            axis_in = stk_axis[top_idx]; sp_in = sp_ff - SP_W'(1);
         end
         kdr_pkg::OP_WK_START: begin
            lo_in = '0; cnt_in = count_ff; axis_in = kdr_pkg::AXIS_X; sp_in = '0;
            tv_in = 1'b1; pend_v_in = 1'b0; hits_in = '0;
            r2_in = R2_W'(r_ff) * R2_W'(r_ff);
         end
         kdr_pkg::OP_WK_RDORD: begin
            order_re = 1'b1; order_ra = IDX_W'(lo_ff + mid);
         end
         kdr_pkg::OP_WK_RDSLOT: begin
            slot_re = 1'b1; slot_ra = order_rd_ff;
         end
         kdr_pkg::OP_WK_DIFF: begin
            dx_in  = abs_diff(slot_rd_ff[C-1:0], cx_ff);
            dy_in  = abs_diff(slot_rd_ff[2*C-1:C], cy_ff);
            dz_in  = abs_diff(slot_rd_ff[3*C-1:2*C], cz_ff);
            lok_in = (c_ext - r_ext) <= p_ext;
            rok_in = (c_ext + r_ext) >= p_ext;
            nid_in = slot_rd_ff[SLOT_W-1 -: IW];
         end
         kdr_pkg::OP_WK_SQ: begin
            sqx_in = SQ_W'(dx_ff) * SQ_W'(dx_ff);
            sqy_in = SQ_W'(dy_ff) * SQ_W'(dy_ff);
            sqz_in = SQ_W'(dz_ff) * SQ_W'(dz_ff);
         end
         kdr_pkg::OP_WK_SUM: hit_in = (sq_sum <= SUM_W'(r2_ff));
         kdr_pkg::OP_WK_TAKE: begin
            // release the held hit, hold this one until the next is known
            if (pend_v_ff) begin
               ov_in = 1'b1; oid_in = pend_ff; omv_in = 1'b1; opr_in = 1'b0;
               ost_in = kdr_pkg::STATUS_OK; olast_in = 1'b0;
            end
            pend_in = nid_ff; pend_v_in = 1'b1; hits_in = hits_ff + HIT_W'(1);
         end
         kdr_pkg::OP_EMIT_LAST: begin
            ov_in = 1'b1; oid_in = pend_v_ff ? pend_ff : '0; omv_in = pend_v_ff;
            opr_in = 1'b0; ost_in = kdr_pkg::STATUS_OK; olast_in = 1'b1;
            pend_v_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (slot_we) slot_mem[slot_wa] <= slot_wd;
      if (slot_re) slot_rd_ff <= slot_mem[slot_ra];
      if (order_we) order_mem[order_wa] <= order_wd;
      if (order_re) order_rd_ff <= order_mem[order_ra];
      if (push) begin
         stk_lo[sp_ff[SPI_W-1:0]]   <= r_lo;
         stk_cnt[sp_ff[SPI_W-1:0]]  <= r_cnt;
         stk_axis[sp_ff[SPI_W-1:0]] <= nxt_axis;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         tv_ff     <= 1'b0;
         sp_ff     <= '0;
         pend_v_ff <= 1'b0;
         hits_ff   <= '0;
         ov_ff     <= 1'b0;
      end else begin
         count_ff  <= count_in;
         tv_ff     <= tv_in;
         sp_ff     <= sp_in;
         pend_v_ff <= pend_v_in;
         hits_ff   <= hits_in;
         ov_ff     <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in; id_ff <= id_in; cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in;
      r_ff <= r_in; r2_ff <= r2_in; st_ff <= st_in; pr_ff <= pr_in;
      i_ff <= i_in; j_ff <= j_in; key_ff <= key_in; tmp_ff <= tmp_in; kv_ff <= kv_in;
      lo_ff <= lo_in; cnt_ff <= cnt_in; axis_ff <= axis_in;
      dx_ff <= dx_in; dy_ff <= dy_in; dz_ff <= dz_in;
      sqx_ff <= sqx_in; sqy_ff <= sqy_in; sqz_ff <= sqz_in;
      lok_ff <= lok_in; rok_ff <= rok_in; hit_ff <= hit_in; nid_ff <= nid_in;
      pend_ff <= pend_in;
      oid_ff <= oid_in; omv_ff <= omv_in; opr_ff <= opr_in; ost_ff <= ost_in;
      olast_ff <= olast_in;
   end

   assign rsp_valid       = ov_ff;
   assign rsp_match_id    = oid_ff;
   assign rsp_match_valid = omv_ff;
   assign rsp_present     = opr_ff;
   assign rsp_status      = ost_ff;
   assign rsp_last        = olast_ff;

endmodule

// ----- design/kd_tree_radius_search_core.sv -----
// Top level of the k-d tree radius search core: stream ports, controller and datapath.
// Clear, add and spare codes answer without a scan; delete and membership scan the table
//   one slot at a time, stopping at the first match; a query walks the tree node by node.
// Throughput: one item at a time; a stale index is first rebuilt by insertion sort per
//   node range.
// Reset: synchronous; the table comes up empty and the index stale, no clearing pass.
`timescale 1ns / 1ps
module kd_tree_radius_search_core #(
   parameter int CAPACITY   = kdr_pkg::CAPACITY_DEF,
   parameter int COORD_BITS = kdr_pkg::COORD_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   // req_tdata, lowest bit up: func, entry_id, pos_x, pos_y, pos_z, radius, zero pad
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((18 + 4 * COORD_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // rsp_tdata, lowest bit up: match_id, match_valid, present, status, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast
);

   localparam int C     = COORD_BITS;
   localparam int IW    = kdr_pkg::ID_W;
   localparam int ID_LO = 3;
   localparam int X_LO  = ID_LO + IW;
   localparam int Y_LO  = X_LO + C;
   localparam int Z_LO  = Y_LO + C;
   localparam int R_LO  = Z_LO + C;

   kdr_pkg::dp_cmd_type  cmd;
   kdr_pkg::dp_stat_type stat;

   logic [IW-1:0] match_id;
   logic          match_valid, present;
   logic [1:0]    status;

   // Sequence each item: capture, then scan, rebuild or walk as the operation asks.
   kdr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Table, tree order, node stack, distance math and the result register.
   kdr_datapath #(
      .CAPACITY   (CAPACITY),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_func        (req_tdata[2:0]),
      .req_entry_id    (req_tdata[X_LO-1:ID_LO]),
      .req_pos_x       (req_tdata[Y_LO-1:X_LO]),
      .req_pos_y       (req_tdata[Z_LO-1:Y_LO]),
      .req_pos_z       (req_tdata[R_LO-1:Z_LO]),
      .req_radius      (req_tdata[R_LO+C-2:R_LO]),
      .rsp_ready       (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .rsp_match_id    (match_id),
      .rsp_match_valid (match_valid),
      .rsp_present     (present),
      .rsp_status      (status),
      .rsp_last        (rsp_tlast)
   );

   // Pack the result fields, pad to whole bytes.
   assign rsp_tdata = {4'b0000, status, present, match_valid, match_id};

   // A query hit never carries an error status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[16] |-> rsp_tdata[19:18] == kdr_pkg::STATUS_OK)
      else $error("query hit with nonzero status");

   // Hit and membership answer come from different operations.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[16] && rsp_tdata[17]))
      else $error("hit and present both set");

   // One item at a time: no accept in the cycle after an accept.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while busy");

   // No held query hit is left over once the block is idle.
   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> stat.pend_valid == 1'b0)
      else $error("held hit left over at idle");

endmodule

// ----- dv/tb_kd_tree_radius_search_core.sv -----
// Self-checking testbench of the k-d tree radius search core: directed and random items.
`timescale 1ns / 1ps
module tb_kd_tree_radius_search_core;

   localparam int CAP      = kdr_pkg::CAPACITY_DEF;
   localparam int CB       = kdr_pkg::COORD_BITS_DEF;
   localparam int IDW      = kdr_pkg::ID_W;
   localparam int REQ_W    = ((18 + 4 * CB + 7) / 8) * 8;
   localparam int WDOG_MAX = 300000;
   localparam int DRAIN    = 200;
   localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
   localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [2:0]          func;
      logic [IDW-1:0]      entry_id;
      logic signed [CB-1:0] px;
      logic signed [CB-1:0] py;
      logic signed [CB-1:0] pz;
      logic [CB-2:0]       radius;
      logic [1:0]          phase;
   } op_item_type;

   typedef struct packed {
      logic [IDW-1:0]  match_id;
      logic            match_valid;
      logic            present;
      logic [1:0]      status;
      logic            last;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic rsp_tlast;

   kd_tree_radius_search_core DUT (.*);

   always #5 clock = ~clock;

   op_item_type pending_ops[$];
   answer_type  expected_answers[$];
   logic [1:0] cur_phase = 2'd0;
   int   n_driven = 0;
   int   errors = 0;
   int   idle_cycles = 0;
   int   n_ops = 0, n_answers = 0, n_hits = 0, n_full = 0;

   // Shadow copy of the entry table and the tree order.
   logic [IDW-1:0]  tbl_id[CAP];
   longint          tbl_pos[CAP][3];
   int              tbl_count = 0;
   int              order[CAP];
   bit              index_ok = 0;
   longint          q_ctr[3];
   longint          q_rad, q_rad2;
   int              q_hits;

   function automatic void add_answer(logic [IDW-1:0] id, logic mv, logic pr,
                                      logic [1:0] st);
      answer_type a;
      a.match_id = id; a.match_valid = mv; a.present = pr; a.status = st; a.last = 1'b0;
      expected_answers = {expected_answers, a};
   endfunction

   function automatic void sort_range(int lo, int cnt, int axis);
      int key, j;
      for (int i = 1; i < cnt; i++) begin
         key = order[lo + i];
         j = i;
         while (j > 0 && tbl_pos[order[lo + j - 1]][axis] > tbl_pos[key][axis]) begin
            order[lo + j] = order[lo + j - 1];
            j--;
         end
         order[lo + j] = key;
      end
   endfunction

   function automatic void rebuild(int lo, int cnt, int axis);
      int mid;
      if (cnt == 0) return;
      sort_range(lo, cnt, axis);
      mid = cnt / 2;
      if (mid > 0) rebuild(lo, mid, (axis + 1) % 3);
      if (mid + 1 < cnt) rebuild(lo + mid + 1, cnt - mid - 1, (axis + 1) % 3);
   endfunction

   function automatic void search(int lo, int cnt, int axis);
      int mid, s;
      longint d, dd, p;
      if (cnt == 0) return;
      mid = cnt / 2;
      s = order[lo + mid];
      dd = 0;
      for (int a = 0; a < 3; a++) begin
         d = tbl_pos[s][a] - q_ctr[a];
         dd += d * d;
      end
      if (dd <= q_rad2 && q_hits < kdr_pkg::MAX_RESULTS) begin
         add_answer(tbl_id[s], 1'b1, 1'b0, kdr_pkg::STATUS_OK);
         q_hits++;
      end
      p = tbl_pos[s][axis];
      if (q_ctr[axis] - q_rad <= p) search(lo, mid, (axis + 1) % 3);
      if (q_ctr[axis] + q_rad >= p) search(lo + mid + 1, cnt - mid - 1, (axis + 1) % 3);
   endfunction

   // Work out the answers of one accepted item and update the shadow table.
   function automatic void predict_answers(logic [REQ_W-1:0] d);
      logic [2:0]       f;
      logic [IDW-1:0]   id;
      logic [1:0]       st;
      logic             pr;
      int               t;
      f  = d[2:0];
      id = d[18:3];
      st = kdr_pkg::STATUS_NOTFOUND;
      pr = 1'b0;
      if (f == kdr_pkg::FUNC_CLEAR) begin
         tbl_count = 0; index_ok = 0;
         add_answer('0, 1'b0, 1'b0, kdr_pkg::STATUS_OK);
      end else if (f == kdr_pkg::FUNC_ADD) begin
         if (tbl_count >= CAP) begin
            add_answer('0, 1'b0, 1'b0, kdr_pkg::STATUS_FULL);
            n_full++;
         end else begin
            tbl_id[tbl_count] = id;
            tbl_pos[tbl_count][0] = longint'($signed(d[18+CB:19]));
            tbl_pos[tbl_count][1] = longint'($signed(d[18+2*CB:19+CB]));
            tbl_pos[tbl_count][2] = longint'($signed(d[18+3*CB:19+2*CB]));
            tbl_count++; index_ok = 0;
            add_answer('0, 1'b0, 1'b0, kdr_pkg::STATUS_OK);
         end
      end else if (f == kdr_pkg::FUNC_DELETE) begin
         for (int i = 0; i < tbl_count; i++) begin
            if (tbl_id[i] == id) begin
               t = tbl_count - 1;
               tbl_id[i] = tbl_id[t];
               tbl_pos[i] = tbl_pos[t];
               tbl_count = t; index_ok = 0; st = kdr_pkg::STATUS_OK;
               break;
            end
         end
         add_answer('0, 1'b0, 1'b0, st);
      end else if (f == kdr_pkg::FUNC_MEMBER) begin
         for (int i = 0; i < tbl_count; i++)
            if (tbl_id[i] == id) pr = 1'b1;
         add_answer('0, 1'b0, pr, kdr_pkg::STATUS_OK);
      end else if (f == kdr_pkg::FUNC_QUERY) begin
         if (!index_ok) begin
            for (int i = 0; i < tbl_count; i++) order[i] = i;
            rebuild(0, tbl_count, 0);
            index_ok = 1;
         end
         q_ctr[0] = longint'($signed(d[18+CB:19]));
         q_ctr[1] = longint'($signed(d[18+2*CB:19+CB]));
         q_ctr[2] = longint'($signed(d[18+3*CB:19+2*CB]));
         q_rad  = longint'(d[17+4*CB:19+3*CB]);
         q_rad2 = q_rad * q_rad;
         q_hits = 0;
         search(0, tbl_count, 0);
         n_hits += q_hits;
         if (q_hits == 0) add_answer('0, 1'b0, 1'b0, kdr_pkg::STATUS_OK);
      end else begin
         add_answer('0, 1'b0, 1'b0, kdr_pkg::STATUS_OK);
      end
      expected_answers[$].last = 1'b1;
   endfunction

   // Drive the request side at the falling edge; load a new item once the last is taken.
   always @(negedge clock) begin
      op_item_type it;
      if (!reset && (!req_tvalid || n_ops == n_driven)) begin
         if (pending_ops.size() > 0 &&
             !((pending_ops[0].phase == 2'd1 && $urandom_range(99) < 52) ||
               (pending_ops[0].phase == 2'd3 && $urandom_range(99) < 8))) begin
            it = pending_ops.pop_front();
            n_driven++;
            cur_phase <= it.phase;
            req_tdata <= {{(REQ_W - 18 - 4 * CB){1'b0}}, it.radius, it.pz, it.py, it.px,
                          it.entry_id, it.func};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Stall the result side according to the phase of the last item sent.
   always @(negedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else if (cur_phase == 2'd2)
         rsp_tready <= $urandom_range(99) >= 52;
      else if (cur_phase == 2'd3)
         rsp_tready <= $urandom_range(99) >= 8;
      else
         rsp_tready <= 1'b1;
   end

   // Sample both handshakes at the rising edge, compare, and watch for a hang.
   always @(posedge clock) begin
      answer_type exp_a, got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            n_ops++;
            predict_answers(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            n_answers++;
            got = {rsp_tdata[15:0], rsp_tdata[16], rsp_tdata[17], rsp_tdata[19:18], rsp_tlast};
            if (expected_answers.size() == 0) begin
               $display("%0t: unexpected answer %h", $time, got);
               errors++;
            end else begin
               exp_a = expected_answers.pop_front();
               if (got !== exp_a) begin
                  $display("%0t: mismatch expected id=%h mv=%b pr=%b st=%0d last=%b",
                           $time, exp_a.match_id, exp_a.match_valid, exp_a.present,
                           exp_a.status, exp_a.last);
                  $display("%0t:          actual   id=%h mv=%b pr=%b st=%0d last=%b",
                           $time, got.match_id, got.match_valid, got.present,
                           got.status, got.last);
                  errors++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WDOG_MAX) begin
            $display("%0t: no progress for %0d cycles", $time, WDOG_MAX);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   task automatic queue_op(logic [2:0] f, logic [IDW-1:0] id, int x, int y, int z,
                           int r, logic [1:0] ph);
      op_item_type it;
      it.func = f; it.entry_id = id;
      it.px = x[CB-1:0]; it.py = y[CB-1:0]; it.pz = z[CB-1:0];
      it.radius = r[CB-2:0]; it.phase = ph;
      pending_ops = {pending_ops, it};
   endtask

   function automatic int rand_coord();
      if ($urandom_range(99) < 80) return int'($urandom_range(2000)) - 1000;
      return int'($urandom);
   endfunction

   function automatic int rand_radius();
      int k;
      k = $urandom_range(99);
      if (k < 70) return $urandom_range(800);
      if (k < 90) return $urandom;
      return (1 << (CB - 1)) - 1;
   endfunction

   function automatic logic [IDW-1:0] rand_id();
      if ($urandom_range(99) < 85) return IDW'($urandom_range(31));
      return IDW'($urandom);
   endfunction

   localparam int CMAX = (1 << (CB - 1)) - 1;
   localparam int CMIN = -(1 << (CB - 1));

   initial begin
      int k;
      logic [1:0] ph;
      // Directed: empty table, extremes, duplicates, misses and spare codes.
      queue_op(kdr_pkg::FUNC_QUERY,  0, 0, 0, 0, 5, 0);
      queue_op(kdr_pkg::FUNC_MEMBER, 7, 0, 0, 0, 0, 0);
      queue_op(kdr_pkg::FUNC_DELETE, 7, 0, 0, 0, 0, 0);
      queue_op(kdr_pkg::FUNC_ADD, 16'hFFFF, CMAX, CMAX, CMAX, 0, 0);
      queue_op(kdr_pkg::FUNC_ADD, 16'h0000, CMIN, CMIN, CMIN, 0, 0);
      queue_op(kdr_pkg::FUNC_ADD, 16'h0005, 0, 0, 0, 0, 0);
      queue_op(kdr_pkg::FUNC_ADD, 16'h0005, 3, -4, 0, 0, 0);
      queue_op(kdr_pkg::FUNC_ADD, 16'h1234, CMAX, CMIN, 0, 0, 0);
      queue_op(kdr_pkg::FUNC_QUERY, 0, CMIN, CMAX, CMIN, CMAX, 0);
      queue_op(kdr_pkg::FUNC_QUERY, 0, 0, 0, 0, 5, 0);
      queue_op(kdr_pkg::FUNC_QUERY, 0, 0, 0, 0, 4, 0);
      queue_op(kdr_pkg::FUNC_QUERY, 0, 100, 100, 100, 1, 0);
      queue_op(kdr_pkg::FUNC_MEMBER, 16'h0005, 0, 0, 0, 0, 0);
      queue_op(kdr_pkg::FUNC_DELETE, 16'h0005, 0, 0, 0, 0, 0);
      queue_op(kdr_pkg::FUNC_MEMBER, 16'h0005, 0, 0, 0, 0, 0);
      queue_op(kdr_pkg::FUNC_QUERY, 0, 0, 0, 0, 5, 0);
      queue_op(kdr_pkg::FUNC_DELETE, 16'h0abc, 0, 0, 0, 0, 0);
      queue_op(FUNC_SPARE_LO, 16'hFFFF, -1, -1, -1, CMAX, 0);
      queue_op(FUNC_SPARE_HI, 0, 0, 0, 0, 0, 0);
      queue_op(kdr_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0, 0);
      queue_op(kdr_pkg::FUNC_MEMBER, 16'hFFFF, 0, 0, 0, 0, 0);
      // Random, four phases (none, request idling, result stalls, both); each phase fills past capacity once.
      for (int i = 0; i < 212; i++) begin
         ph = 2'(i / 53);
         if (i % 53 == 10) begin
            for (int j = 0; j < CAP + 2; j++)
               queue_op(kdr_pkg::FUNC_ADD, rand_id(), rand_coord(), rand_coord(),
                        rand_coord(), 0, ph);
            queue_op(kdr_pkg::FUNC_QUERY, 0, rand_coord(), rand_coord(), rand_coord(),
                     rand_radius(), ph);
         end
         k = $urandom_range(99);
         if (k < 2)
            queue_op(kdr_pkg::FUNC_CLEAR, rand_id(), 0, 0, 0, 0, ph);
         else if (k < 42)
            queue_op(kdr_pkg::FUNC_ADD, rand_id(), rand_coord(), rand_coord(), rand_coord(),
                     rand_radius(), ph);
         else if (k < 57)
            queue_op(kdr_pkg::FUNC_DELETE, rand_id(), rand_coord(), 0, 0, 0, ph);
         else if (k < 72)
            queue_op(kdr_pkg::FUNC_MEMBER, rand_id(), 0, rand_coord(), 0, 0, ph);
         else if (k < 96)
            queue_op(kdr_pkg::FUNC_QUERY, rand_id(), rand_coord(), rand_coord(),
                     rand_coord(), rand_radius(), ph);
         else
            queue_op(3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI)), rand_id(),
                     rand_coord(), rand_coord(), rand_coord(), rand_radius(), ph);
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      wait (pending_ops.size() == 0);
      @(posedge clock);
      while (req_tvalid || expected_answers.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      $display("Ran %0d items, %0d answers, %0d query hits, %0d adds to a full table.",
               n_ops, n_answers, n_hits, n_full);
      if (errors == 0 && expected_answers.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
